/* hw/rtl/etbc_pkg.sv */
`timescale 1ns / 1ps

package etbc_pkg;

    localparam int CHANNELS    = 4;
    localparam int CMD_W       = 2;
    localparam int CHAN_W      = 2;
    localparam int TIME_W      = 64;
    localparam int PERIOD_W    = 32;
    localparam int MASK_W      = 4;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 72;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(999999);
    localparam logic [TIME_W-1:0]   TIME_MAX     = {TIME_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_ARM  = 2'd1,
        CMD_STOP = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    // decoded command strobes for one item being processed
    typedef struct packed {
        logic              tick;
        logic              arm;
        logic              stop;
        logic [CHAN_W-1:0] channel;
    } etbc_ctrl_t;

endpackage

/* hw/rtl/etbc_time_base.sv */
`timescale 1ns / 1ps

module etbc_time_base (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              tick,
    input  logic [etbc_pkg::PERIOD_W-1:0]     period_count,
    output logic [etbc_pkg::TIME_W-1:0]       now,
    output logic [etbc_pkg::TIME_W-1:0]       now_inc
);

    logic [etbc_pkg::PERIOD_W-1:0] position_reg;
    logic [etbc_pkg::PERIOD_W-1:0] position_next;
    logic [etbc_pkg::TIME_W-1:0]   elapsed_reg;
    logic [etbc_pkg::TIME_W-1:0]   elapsed_next;

    assign now     = elapsed_reg;
    assign now_inc = elapsed_reg + etbc_pkg::TIME_W'(1);

    always_comb begin
        position_next = position_reg;
        elapsed_next  = elapsed_reg;
        if (tick) begin
            elapsed_next = now_inc;
            // wraps also when the period was lowered below the counter
            if (position_reg >= period_count) begin
                position_next = '0;
            end else begin
                position_next = position_reg + etbc_pkg::PERIOD_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            elapsed_reg  <= '0;
        end else begin
            position_reg <= position_next;
            elapsed_reg  <= elapsed_next;
        end
    end

endmodule

/* hw/rtl/etbc_channel_bank.sv */
`timescale 1ns / 1ps

module etbc_channel_bank (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  etbc_pkg::etbc_ctrl_t              ctrl,
    input  logic [etbc_pkg::TIME_W-1:0]       deadline,
    input  logic [etbc_pkg::TIME_W-1:0]       now,
    input  logic [etbc_pkg::TIME_W-1:0]       now_inc,
    output logic [etbc_pkg::CHANNELS-1:0]     fired
);

    logic [etbc_pkg::CHANNELS-1:0] armed_reg;
    logic [etbc_pkg::CHANNELS-1:0] armed_next;
    logic [etbc_pkg::TIME_W-1:0]   deadline_reg  [etbc_pkg::CHANNELS];
    logic [etbc_pkg::TIME_W-1:0]   deadline_next [etbc_pkg::CHANNELS];

    for (genvar c = 0; c < etbc_pkg::CHANNELS; c++) begin : g_chan
        logic sel;
        // out-of-range channel numbers match no channel and are ignored
        assign sel = (32'(ctrl.channel) == 32'(c));

        always_comb begin
            armed_next[c]    = armed_reg[c];
            deadline_next[c] = deadline_reg[c];
            fired[c]         = 1'b0;
            if (ctrl.tick) begin
                fired[c] = armed_reg[c] && (deadline_reg[c] <= now_inc);
            end else if (ctrl.arm && sel) begin
                armed_next[c]    = 1'b1;
                deadline_next[c] = deadline;
                fired[c]         = (deadline <= now);
            end else if (ctrl.stop && sel) begin
                armed_next[c] = 1'b0;
            end
            if (fired[c]) begin
                armed_next[c]    = 1'b0;
                deadline_next[c] = etbc_pkg::TIME_MAX;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                armed_reg[c]    <= 1'b0;
                deadline_reg[c] <= etbc_pkg::TIME_MAX;
            end else begin
                armed_reg[c]    <= armed_next[c];
                deadline_reg[c] <= deadline_next[c];
            end
        end
    end

endmodule

/* hw/rtl/extended_time_base_compare_timer_unit.sv */
`timescale 1ns / 1ps
// an accepted item passes the input register, then the result register, which drives m_tvalid
// throughput: one item per cycle if m_tready; timer state updates in one pass at the result register
// s_tready stays high while the result register is free or being taken on the same edge
// reset (aresetn low, synchronous): time and counter zero, all channels disarmed with deadline
// at maximum, period back to 999999, both pipeline registers empty

module extended_time_base_compare_timer_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [etbc_pkg::PERIOD_W-1:0]       cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [etbc_pkg::S_TDATA_W-1:0]      s_tdata,   // [1:0] channel, [65:2] deadline
    input  logic [etbc_pkg::CMD_W-1:0]          s_tuser,   // [1:0] command
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [etbc_pkg::M_TDATA_W-1:0]      m_tdata    // [3:0] fired_mask, [67:4] current_time
);

    logic [etbc_pkg::PERIOD_W-1:0] period_reg;

    logic                          in_valid_reg;
    logic [etbc_pkg::CMD_W-1:0]    in_cmd_reg;
    logic [etbc_pkg::CHAN_W-1:0]   in_chan_reg;
    logic [etbc_pkg::TIME_W-1:0]   in_deadline_reg;

    logic                          out_valid_reg;
    logic [etbc_pkg::MASK_W-1:0]   out_mask_reg;
    logic [etbc_pkg::TIME_W-1:0]   out_time_reg;
    logic [etbc_pkg::MASK_W-1:0]   out_mask_next;
    logic [etbc_pkg::TIME_W-1:0]   out_time_next;

    logic                          advance;
    logic                          do_item;
    etbc_pkg::etbc_ctrl_t          ctrl;
    logic [etbc_pkg::TIME_W-1:0]   now;
    logic [etbc_pkg::TIME_W-1:0]   now_inc;
    logic [etbc_pkg::CHANNELS-1:0] fired;

    assign advance  = !out_valid_reg || m_tready;
    assign do_item  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        ctrl         = '0;
        ctrl.channel = in_chan_reg;
        if (do_item) begin
            case (etbc_pkg::cmd_t'(in_cmd_reg))
                etbc_pkg::CMD_TICK: ctrl.tick = 1'b1;
                etbc_pkg::CMD_ARM:  ctrl.arm  = 1'b1;
                etbc_pkg::CMD_STOP: ctrl.stop = 1'b1;
                default:            ctrl      = '0;
            endcase
        end
    end

    etbc_time_base u_time_base (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick         (ctrl.tick),
        .period_count (period_reg),
        .now          (now),
        .now_inc      (now_inc)
    );

    etbc_channel_bank u_channel_bank (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .deadline (in_deadline_reg),
        .now      (now),
        .now_inc  (now_inc),
        .fired    (fired)
    );

    // only the low channels are visible in the mask
    for (genvar i = 0; i < etbc_pkg::MASK_W; i++) begin : g_mask
        if (i < etbc_pkg::CHANNELS) begin : g_on
            assign out_mask_next[i] = fired[i];
        end else begin : g_off
            assign out_mask_next[i] = 1'b0;
        end
    end

    assign out_time_next = ctrl.tick ? now_inc : now;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= etbc_pkg::PERIOD_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                period_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg      <= s_tuser;
            in_chan_reg     <= s_tdata[etbc_pkg::CHAN_W-1:0];
            in_deadline_reg <= s_tdata[etbc_pkg::CHAN_W +: etbc_pkg::TIME_W];
        end
        if (do_item) begin
            out_mask_reg <= out_mask_next;
            out_time_reg <= out_time_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(etbc_pkg::M_TDATA_W - etbc_pkg::MASK_W - etbc_pkg::TIME_W){1'b0}},
                       out_time_reg, out_mask_reg};

endmodule
